### rtl/core/jlp_pkg.sv
// ----------------------------------------------------------------------------
// jlp_pkg
// Shared types and constants for the joystick link poller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jlp_pkg;

	localparam logic [7:0] START_BYTE = 8'hFF;
	localparam logic [7:0] REQ_LEFT   = 8'hBB;
	localparam logic [7:0] REQ_RIGHT  = 8'hCC;
	localparam logic [7:0] STOP_TAG   = 8'hAA;

	localparam int unsigned TIMEOUT_W     = 16;
	localparam int unsigned VALUE_W       = 8;
	localparam int unsigned CFG_DATA_W    = 16;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd180;
	localparam logic [VALUE_W-1:0]   NEUTRAL_RESET = 8'd127;

	localparam logic CFG_TIMEOUT = 1'b0;
	localparam logic CFG_NEUTRAL = 1'b1;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_POLL = 1'b1;

	localparam int unsigned STICK_LX = 0;
	localparam int unsigned STICK_LY = 1;
	localparam int unsigned STICK_RX = 2;
	localparam int unsigned STICK_RY = 3;

	typedef enum logic [1:0] {
		PH_SLEEP = 2'd0,
		PH_LEFT  = 2'd1,
		PH_RIGHT = 2'd2
	} phase_t;

	typedef struct packed {
		logic                      frame_open;
		logic [1:0]                byte_slot;
		phase_t                    phase;
		logic [15:0]               left_wait;
		logic [15:0]               right_wait;
		logic [3:0][7:0]           sticks;
		logic [1:0]                stop_count;
		logic                      start_flag;
	} state_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
	} tx_t;

endpackage

`default_nettype wire

### rtl/core/jlp_step.sv
// ----------------------------------------------------------------------------
// jlp_step
// Next-state and request logic for one poll tick or one received byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jlp_step (
	input  wire jlp_pkg::state_t  st,
	input  wire logic [2:0][7:0]  frame_bytes,
	input  wire logic             cmd,
	input  wire logic [7:0]       rx_byte,
	input  wire logic [15:0]      timeout_polls,
	input  wire logic [7:0]       neutral_value,
	output jlp_pkg::state_t       st_nxt,
	output logic                  fb_we,
	output logic [1:0]            fb_sel,
	output jlp_pkg::tx_t          tx
);

	jlp_pkg::phase_t ph;
	logic [15:0]     lw;
	logic [15:0]     rw;
	logic [7:0]      tag;

	always_comb begin
		st_nxt      = st;
		fb_we       = 1'b0;
		fb_sel      = st.byte_slot;
		tx.tx_valid = 1'b0;
		tx.tx_byte  = 8'h00;
		ph          = st.phase;
		lw          = st.left_wait;
		rw          = st.right_wait;
		tag         = frame_bytes[0];

		if (cmd == jlp_pkg::CMD_POLL) begin
			if (st.stop_count == 2'd0) begin
				if (st.phase == jlp_pkg::PH_SLEEP) begin
					ph          = jlp_pkg::PH_LEFT;
					tx.tx_valid = 1'b1;
					tx.tx_byte  = jlp_pkg::REQ_LEFT;
				end
				unique case (ph)
					jlp_pkg::PH_LEFT: begin
						lw = (st.left_wait == 16'hFFFF) ? st.left_wait : st.left_wait + 16'd1;
						rw = 16'd0;
					end
					jlp_pkg::PH_RIGHT: begin
						lw = 16'd0;
						rw = (st.right_wait == 16'hFFFF) ? st.right_wait : st.right_wait + 16'd1;
					end
					default: begin
						lw = 16'd0;
						rw = 16'd0;
					end
				endcase
				if (lw >= timeout_polls || rw >= timeout_polls) begin
					st_nxt.sticks = {4{neutral_value}};
					ph            = jlp_pkg::PH_SLEEP;
					lw            = 16'd0;
					rw            = 16'd0;
				end
				st_nxt.phase      = ph;
				st_nxt.left_wait  = lw;
				st_nxt.right_wait = rw;
			end
		end else begin
			if (!st.frame_open) begin
				st_nxt.frame_open = (rx_byte == jlp_pkg::START_BYTE);
				st_nxt.byte_slot  = 2'd0;
			end else if (st.byte_slot != 2'd3) begin
				fb_we            = 1'b1;
				st_nxt.byte_slot = st.byte_slot + 2'd1;
			end else if (rx_byte == jlp_pkg::START_BYTE) begin
				st_nxt.frame_open = 1'b0;
				st_nxt.byte_slot  = 2'd0;
				if (tag == jlp_pkg::REQ_LEFT) begin
					if (st.phase == jlp_pkg::PH_LEFT) begin
						st_nxt.sticks[jlp_pkg::STICK_LY] = frame_bytes[1];
						st_nxt.sticks[jlp_pkg::STICK_LX] = frame_bytes[2];
						st_nxt.phase = jlp_pkg::PH_RIGHT;
						tx.tx_valid  = 1'b1;
						tx.tx_byte   = jlp_pkg::REQ_RIGHT;
					end
				end else if (tag == jlp_pkg::REQ_RIGHT) begin
					if (st.phase == jlp_pkg::PH_RIGHT) begin
						st_nxt.sticks[jlp_pkg::STICK_RY] = frame_bytes[1];
						st_nxt.sticks[jlp_pkg::STICK_RX] = frame_bytes[2];
						st_nxt.phase = jlp_pkg::PH_SLEEP;
					end
				end else begin
					st_nxt.sticks = {4{neutral_value}};
					st_nxt.phase  = jlp_pkg::PH_SLEEP;
				end
				if (tag == jlp_pkg::STOP_TAG) begin
					st_nxt.stop_count = st.stop_count + 2'd1;
					st_nxt.start_flag = 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/joystick_link_poller.sv
// ----------------------------------------------------------------------------
// joystick_link_poller
// Polls a two-stick remote over a byte link and deframes its replies.
// ----------------------------------------------------------------------------
// Usage: each input transaction carries either a poll tick (cmd = 1) or one
// received link byte (cmd = 0). Every input transaction yields exactly one
// output transaction that reports the request byte to send, if any, and the
// current stick values, stop mode, start flag and link phase.
// The input lands in a register, one level of logic updates the link state,
// and the result is held in an output register until the receiver takes it;
// one transaction per cycle is sustained while the receiver does not stall.
// When the receiver stalls, the output register holds its result and the
// input register fills; input stall then rises until the output drains.
// Reset clears the link to sleep, both wait counters, the stop mode and the
// start flag, sets the sticks and neutral value to 127 and the timeout to 180.
// Configuration writes (timeout at index 0, neutral value at index 1) must
// only be issued while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module joystick_link_poller (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic                            cfg_index,
	input  wire logic [jlp_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            cmd,
	input  wire logic [7:0]                      rx_byte,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 tx_valid,
	output logic [7:0]                           tx_byte,
	output logic [7:0]                           left_x,
	output logic [7:0]                           left_y,
	output logic [7:0]                           right_x,
	output logic [7:0]                           right_y,
	output logic [1:0]                           stop_mode,
	output logic                                 start_pressed,
	output logic [1:0]                           link_phase
);

	logic             valid_s1;
	logic             cmd_s1;
	logic [7:0]       rx_byte_s1;
	logic             out_room;
	logic             advance;

	logic [15:0]      timeout_q;
	logic [7:0]       neutral_q;
	jlp_pkg::state_t  st_q;
	jlp_pkg::state_t  st_nxt;
	logic [2:0][7:0]  frame_bytes_q;
	logic             fb_we;
	logic [1:0]       fb_sel;
	jlp_pkg::tx_t     tx;

	logic             out_valid_q;
	jlp_pkg::tx_t     tx_q;
	jlp_pkg::state_t  view_q;

	assign out_room = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_room;
	assign in_stall = valid_s1 && !out_room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1     <= cmd;
			rx_byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= jlp_pkg::TIMEOUT_RESET;
			neutral_q <= jlp_pkg::NEUTRAL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				jlp_pkg::CFG_TIMEOUT: timeout_q <= cfg_data;
				jlp_pkg::CFG_NEUTRAL: neutral_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	jlp_step u_step (
		.st            (st_q),
		.frame_bytes   (frame_bytes_q),
		.cmd           (cmd_s1),
		.rx_byte       (rx_byte_s1),
		.timeout_polls (timeout_q),
		.neutral_value (neutral_q),
		.st_nxt        (st_nxt),
		.fb_we         (fb_we),
		.fb_sel        (fb_sel),
		.tx            (tx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{
				frame_open: 1'b0,
				byte_slot:  2'd0,
				phase:      jlp_pkg::PH_SLEEP,
				left_wait:  16'd0,
				right_wait: 16'd0,
				sticks:     {4{jlp_pkg::NEUTRAL_RESET}},
				stop_count: 2'd0,
				start_flag: 1'b0
			};
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && fb_we) begin
			frame_bytes_q[fb_sel] <= rx_byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_room) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tx_q   <= tx;
			view_q <= st_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign tx_valid      = tx_q.tx_valid;
	assign tx_byte       = tx_q.tx_byte;
	assign left_x        = view_q.sticks[jlp_pkg::STICK_LX];
	assign left_y        = view_q.sticks[jlp_pkg::STICK_LY];
	assign right_x       = view_q.sticks[jlp_pkg::STICK_RX];
	assign right_y       = view_q.sticks[jlp_pkg::STICK_RY];
	assign stop_mode     = view_q.stop_count;
	assign start_pressed = view_q.start_flag;
	assign link_phase    = view_q.phase;

endmodule

`default_nettype wire

### rtl/core/jlp_checker.sv
// ----------------------------------------------------------------------------
// jlp_checker
// Port-level assertions for the joystick link poller, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jlp_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       tx_valid,
	input wire logic [7:0] tx_byte,
	input wire logic       start_pressed,
	input wire logic [1:0] link_phase
);

	a_tx_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tx_valid |-> (tx_byte == jlp_pkg::REQ_LEFT || tx_byte == jlp_pkg::REQ_RIGHT))
		else $error("request byte is not a left or right request");

	a_tx_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tx_valid |-> tx_byte == 8'h00)
		else $error("request byte nonzero without a request");

	a_right_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tx_valid && tx_byte == jlp_pkg::REQ_RIGHT
			|-> link_phase == jlp_pkg::PH_RIGHT)
		else $error("right request without awaiting right");

	a_start_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && start_pressed |=> start_pressed)
		else $error("start flag cleared");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(tx_byte) && $stable(link_phase))
		else $error("stalled output transaction changed");

endmodule

bind joystick_link_poller jlp_checker u_jlp_checker (.*);

`default_nettype wire

### bench/jlp_reply_checker.sv
// ----------------------------------------------------------------------------
// jlp_reply_checker
// Watches both channels of the joystick link poller and checks its outputs.
// Every accepted input transaction is run through a local model of the link
// state, which queues the status the block must report for it. Every accepted
// output transaction is compared field by field with the oldest queued status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jlp_reply_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic                            cfg_index,
	input  wire logic [jlp_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            in_valid,
	input  wire logic                            in_stall,
	input  wire logic                            cmd,
	input  wire logic [7:0]                      rx_byte,
	input  wire logic                            out_valid,
	input  wire logic                            out_stall,
	input  wire logic                            tx_valid,
	input  wire logic [7:0]                      tx_byte,
	input  wire logic [7:0]                      left_x,
	input  wire logic [7:0]                      left_y,
	input  wire logic [7:0]                      right_x,
	input  wire logic [7:0]                      right_y,
	input  wire logic [1:0]                      stop_mode,
	input  wire logic                            start_pressed,
	input  wire logic [1:0]                      link_phase,
	output int                                   errors,
	output int                                   pending
);

	typedef struct packed {
		logic             tx_valid;
		logic [7:0]       tx_byte;
		logic [3:0][7:0]  sticks;
		logic [1:0]       stop;
		logic             start;
		jlp_pkg::phase_t  phase;
	} link_status_t;

	link_status_t    status_q[$];

	logic [15:0]      timeout_lim;
	logic [7:0]       neutral;
	logic             frame_open;
	logic [1:0]       byte_slot;
	logic [7:0]       frame_bytes[3];
	jlp_pkg::phase_t  link_ph;
	logic [15:0]      left_wait;
	logic [15:0]      right_wait;
	logic [3:0][7:0]  sticks;
	logic [1:0]       stop_cnt;
	logic             start_flag;

	task automatic report(input string msg);
		$display("%0t ns: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want) begin
			report($sformatf("%s mismatch: got %02h, expected %02h", name, got, want));
		end
	endtask

	task automatic check_status();
		link_status_t want;
		if (status_q.size() == 0) begin
			report($sformatf("output transaction with nothing expected, tx_byte %02h", tx_byte));
			return;
		end
		want = status_q.pop_front();
		check_field("tx_valid", tx_valid, want.tx_valid);
		check_field("tx_byte", tx_byte, want.tx_byte);
		check_field("left_x", left_x, want.sticks[jlp_pkg::STICK_LX]);
		check_field("left_y", left_y, want.sticks[jlp_pkg::STICK_LY]);
		check_field("right_x", right_x, want.sticks[jlp_pkg::STICK_RX]);
		check_field("right_y", right_y, want.sticks[jlp_pkg::STICK_RY]);
		check_field("stop_mode", stop_mode, want.stop);
		check_field("start_pressed", start_pressed, want.start);
		check_field("link_phase", link_phase, want.phase);
	endtask

	task automatic advance_link(input logic is_poll, input logic [7:0] b);
		link_status_t st;
		logic [7:0]   tag;
		st = '0;
		if (is_poll == jlp_pkg::CMD_POLL) begin
			if (stop_cnt == 2'd0) begin
				if (link_ph == jlp_pkg::PH_SLEEP) begin
					link_ph = jlp_pkg::PH_LEFT;
					st.tx_valid = 1'b1;
					st.tx_byte = jlp_pkg::REQ_LEFT;
				end
				case (link_ph)
					jlp_pkg::PH_LEFT: begin
						if (left_wait != 16'hFFFF) left_wait++;
						right_wait = '0;
					end
					jlp_pkg::PH_RIGHT: begin
						left_wait = '0;
						if (right_wait != 16'hFFFF) right_wait++;
					end
					default: begin
						left_wait = '0;
						right_wait = '0;
					end
				endcase
				if (left_wait >= timeout_lim || right_wait >= timeout_lim) begin
					sticks = {4{neutral}};
					link_ph = jlp_pkg::PH_SLEEP;
					left_wait = '0;
					right_wait = '0;
				end
			end
		end else if (!frame_open) begin
			frame_open = (b == jlp_pkg::START_BYTE);
			byte_slot = '0;
		end else if (byte_slot != 2'd3) begin
			frame_bytes[byte_slot] = b;
			byte_slot++;
		end else if (b == jlp_pkg::START_BYTE) begin
			frame_open = 1'b0;
			byte_slot = '0;
			tag = frame_bytes[0];
			if (tag == jlp_pkg::REQ_LEFT) begin
				if (link_ph == jlp_pkg::PH_LEFT) begin
					sticks[jlp_pkg::STICK_LY] = frame_bytes[1];
					sticks[jlp_pkg::STICK_LX] = frame_bytes[2];
					link_ph = jlp_pkg::PH_RIGHT;
					st.tx_valid = 1'b1;
					st.tx_byte = jlp_pkg::REQ_RIGHT;
				end
			end else if (tag == jlp_pkg::REQ_RIGHT) begin
				if (link_ph == jlp_pkg::PH_RIGHT) begin
					sticks[jlp_pkg::STICK_RY] = frame_bytes[1];
					sticks[jlp_pkg::STICK_RX] = frame_bytes[2];
					link_ph = jlp_pkg::PH_SLEEP;
				end
			end else begin
				sticks = {4{neutral}};
				link_ph = jlp_pkg::PH_SLEEP;
			end
			if (tag == jlp_pkg::STOP_TAG) begin
				stop_cnt++;
				start_flag = 1'b1;
			end
		end
		st.sticks = sticks;
		st.stop = stop_cnt;
		st.start = start_flag;
		st.phase = link_ph;
		status_q.push_back(st);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q.delete();
			errors = 0;
			timeout_lim = jlp_pkg::TIMEOUT_RESET;
			neutral = jlp_pkg::NEUTRAL_RESET;
			frame_open = 1'b0;
			byte_slot = '0;
			frame_bytes[0] = '0;
			frame_bytes[1] = '0;
			frame_bytes[2] = '0;
			link_ph = jlp_pkg::PH_SLEEP;
			left_wait = '0;
			right_wait = '0;
			sticks = {4{jlp_pkg::NEUTRAL_RESET}};
			stop_cnt = '0;
			start_flag = 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				check_status();
			end
			if (cfg_we) begin
				if (cfg_index == jlp_pkg::CFG_TIMEOUT) begin
					timeout_lim = cfg_data[jlp_pkg::TIMEOUT_W-1:0];
				end else begin
					neutral = cfg_data[jlp_pkg::VALUE_W-1:0];
				end
			end
			if (in_valid && !in_stall) begin
				advance_link(cmd, rx_byte);
			end
		end
		pending = status_q.size();
	end

endmodule

### bench/tb_joystick_link_poller.sv
// ----------------------------------------------------------------------------
// tb_joystick_link_poller
// Regression bench for the joystick link poller.
// A short directed run covers polls, left and right replies, an ignored stray
// byte, a late end byte, a bad tag and a stop frame. Random traffic follows,
// mostly complete poll and reply exchanges with random stick values, mixed
// with stop frames, poll bursts that run into the timeout, line noise and
// broken frames. Several timeout and neutral settings are used, extremes
// included. The sender idles in bursts, the receiver stalls on its own
// pattern, and a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_joystick_link_poller;

	localparam int QUIET_LIMIT = 2000;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic                           cfg_index = jlp_pkg::CFG_TIMEOUT;
	logic [jlp_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                           in_valid = 1'b0;
	logic                           cmd = jlp_pkg::CMD_POLL;
	logic [7:0]                     rx_byte = '0;
	logic                           out_stall = 1'b0;
	logic                           in_stall;
	logic                           out_valid;
	logic                           tx_valid;
	logic [7:0]                     tx_byte;
	logic [7:0]                     left_x;
	logic [7:0]                     left_y;
	logic [7:0]                     right_x;
	logic [7:0]                     right_y;
	logic [1:0]                     stop_mode;
	logic                           start_pressed;
	logic [1:0]                     link_phase;
	int                             errors;
	int                             pending;

	logic                           stall_on = 1'b0;
	int                             stall_left = 0;
	int                             quiet = 0;
	int                             burst_left = 0;
	int                             items_sent = 0;

	// Framing as the block sees it, used to keep generated frames aligned.
	logic                           g_open = 1'b0;
	int                             g_slot = 0;
	logic [7:0]                     g_tag = '0;
	logic [1:0]                     g_stop = '0;

	joystick_link_poller DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cmd           (cmd),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.tx_valid      (tx_valid),
		.tx_byte       (tx_byte),
		.left_x        (left_x),
		.left_y        (left_y),
		.right_x       (right_x),
		.right_y       (right_y),
		.stop_mode     (stop_mode),
		.start_pressed (start_pressed),
		.link_phase    (link_phase)
	);

	jlp_reply_checker reply_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cmd           (cmd),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.tx_valid      (tx_valid),
		.tx_byte       (tx_byte),
		.left_x        (left_x),
		.left_y        (left_y),
		.right_x       (right_x),
		.right_y       (right_y),
		.stop_mode     (stop_mode),
		.start_pressed (start_pressed),
		.link_phase    (link_phase),
		.errors        (errors),
		.pending       (pending)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (stall_left == 0) begin
			out_stall <= stall_on && ($urandom_range(0, 2) == 0);
			stall_left <= $urandom_range(1, 16);
		end else begin
			stall_left <= stall_left - 1;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
		if (quiet >= QUIET_LIMIT) begin
			$display("joystick_link_poller regression: fail");
			$finish;
		end
	end

	function automatic logic [7:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] pick_tag();
		case ($urandom_range(0, 3))
			0: return jlp_pkg::REQ_LEFT;
			1: return jlp_pkg::REQ_RIGHT;
			2: return jlp_pkg::STOP_TAG;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_item(input logic c, input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		cmd <= c;
		rx_byte <= b;
		@(negedge clk);
		while (in_stall) @(negedge clk);
		@(posedge clk);
		burst_left--;
		items_sent++;
		if (c == jlp_pkg::CMD_BYTE) begin
			if (!g_open) begin
				g_open = (b == jlp_pkg::START_BYTE);
				g_slot = 0;
			end else if (g_slot < 3) begin
				if (g_slot == 0) g_tag = b;
				g_slot++;
			end else if (b == jlp_pkg::START_BYTE) begin
				g_open = 1'b0;
				g_slot = 0;
				if (g_tag == jlp_pkg::STOP_TAG) g_stop++;
			end
		end
	endtask

	task automatic send_poll();
		send_item(jlp_pkg::CMD_POLL, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_frame(input logic [7:0] tag, input logic [7:0] a, input logic [7:0] b,
			input int junk);
		if (g_open) begin
			while (g_slot < 3) send_item(jlp_pkg::CMD_BYTE, 8'($urandom_range(0, 254)));
			send_item(jlp_pkg::CMD_BYTE, jlp_pkg::START_BYTE);
		end
		send_item(jlp_pkg::CMD_BYTE, jlp_pkg::START_BYTE);
		send_item(jlp_pkg::CMD_BYTE, tag);
		send_item(jlp_pkg::CMD_BYTE, a);
		send_item(jlp_pkg::CMD_BYTE, b);
		repeat (junk) send_item(jlp_pkg::CMD_BYTE, 8'($urandom_range(0, 254)));
		send_item(jlp_pkg::CMD_BYTE, jlp_pkg::START_BYTE);
	endtask

	task automatic random_sequence();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			while (g_stop != 2'd0) begin
				send_frame(jlp_pkg::STOP_TAG, pick_value(), pick_value(), 0);
				if ($urandom_range(0, 1) == 1) send_poll();
			end
			repeat ($urandom_range(1, 3)) send_poll();
			send_frame(($urandom_range(0, 9) == 0) ? jlp_pkg::REQ_RIGHT : jlp_pkg::REQ_LEFT,
				pick_value(), pick_value(),
				($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0);
			repeat ($urandom_range(0, 2)) send_poll();
			send_frame(($urandom_range(0, 9) == 0) ? jlp_pkg::REQ_LEFT : jlp_pkg::REQ_RIGHT,
				pick_value(), pick_value(),
				($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0);
		end else if (pick < 65) begin
			repeat ($urandom_range(1, 4)) begin
				send_frame(jlp_pkg::STOP_TAG, pick_value(), pick_value(), 0);
				repeat ($urandom_range(0, 2)) send_poll();
			end
		end else if (pick < 75) begin
			repeat ($urandom_range(1, 10)) send_poll();
		end else if (pick < 85) begin
			repeat ($urandom_range(1, 6)) begin
				send_item(jlp_pkg::CMD_BYTE, ($urandom_range(0, 3) == 0) ? jlp_pkg::START_BYTE
					: 8'($urandom_range(0, 255)));
			end
		end else if (pick < 95) begin
			send_item(jlp_pkg::CMD_BYTE, jlp_pkg::START_BYTE);
			send_item(jlp_pkg::CMD_BYTE, pick_tag());
			send_item(jlp_pkg::CMD_BYTE, pick_value());
			send_item(jlp_pkg::CMD_BYTE, pick_value());
			repeat ($urandom_range(0, 2))
				send_item(jlp_pkg::CMD_BYTE, 8'($urandom_range(0, 254)));
			if ($urandom_range(0, 1) == 1) send_item(jlp_pkg::CMD_BYTE, jlp_pkg::START_BYTE);
		end else begin
			send_frame(8'($urandom_range(0, 255)), pick_value(), pick_value(), 0);
		end
	endtask

	task automatic run_random(input int target);
		while (items_sent < target) random_sequence();
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input logic [15:0] timeout, input logic [7:0] neutral_val);
		cfg_we <= 1'b1;
		cfg_index <= jlp_pkg::CFG_TIMEOUT;
		cfg_data <= timeout;
		@(posedge clk);
		cfg_index <= jlp_pkg::CFG_NEUTRAL;
		cfg_data <= {8'($urandom_range(0, 255)), neutral_val};
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Poll from sleep, then a stray byte outside any frame.
		send_poll();
		send_item(jlp_pkg::CMD_BYTE, 8'h12);
		send_frame(jlp_pkg::REQ_LEFT, 8'h00, 8'hFF, 0);
		send_poll();
		// Right reply with one extra byte before the end byte.
		send_frame(jlp_pkg::REQ_RIGHT, 8'hFF, 8'h00, 1);
		send_frame(8'h33, 8'h01, 8'h02, 0);
		send_frame(jlp_pkg::STOP_TAG, 8'h01, 8'h02, 0);
		send_poll();
		drain();

		configure(16'd1, 8'h00);
		run_random(350);
		drain();

		stall_on <= 1'b1;
		configure(16'hFFFF, 8'hFF);
		run_random(700);
		drain();

		configure(16'($urandom_range(2, 6)), 8'($urandom_range(0, 255)));
		run_random(1150);
		drain();

		configure(16'($urandom_range(1, 65535)), 8'($urandom_range(0, 255)));
		run_random(1400);
		drain();

		configure(16'd3, 8'($urandom_range(0, 255)));
		run_random(1675);
		drain();

		@(negedge clk);
		if (errors == 0 && pending == 0) begin
			$display("joystick_link_poller regression: pass");
		end else begin
			$display("joystick_link_poller regression: fail");
		end
		$finish;
	end

endmodule

### joystick_link_poller.f
rtl/core/jlp_pkg.sv
rtl/core/jlp_step.sv
rtl/core/joystick_link_poller.sv
rtl/core/jlp_checker.sv
bench/jlp_reply_checker.sv
bench/tb_joystick_link_poller.sv
